// ===== sv/wfdd_pkg.sv =====
// Shared definitions for the waits-for deadlock detector.
// Holds field widths, operation codes and the control/status bundles
// exchanged between the controller and the datapath. No dependencies.
`default_nettype none

package wfdd_pkg;

    // Default graph size (number of transaction ids tracked)
    localparam int unsigned DEF_MAX_TXN = 32;

    // Fixed field widths on the item channels
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned ID_FIELD_W = 5;

    // Operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DETECT = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;       // input transfer: latch fields, read waiter row
        logic edit_wr;      // write back edited waiter row
        logic sweep_step;   // one step of the delete-node column sweep
        logic clear_graph;  // drop every adjacency row
        logic det_init;     // clear search masks and counters
        logic start_skip;   // advance to next root id
        logic start_push;   // push root id as path bottom
        logic load_row;     // capture adjacency row of path top
        logic scan_adv;     // move successor cursor by one
        logic scan_pop;     // top is done: mark finished, pop
        logic scan_push;    // push current successor
        logic scan_hit;     // back edge found, start victim walk
        logic pop_restore;  // reload top id and cursor after pop
        logic vic_rd;       // read path entry for victim walk
        logic vic_step;     // compare path entry, track largest id
        logic result_load;  // move result into output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic kind_edit;      // add or remove edge
        logic kind_delete;
        logic kind_clear;
        logic kind_detect;
        logic edit_ok;        // waiter and holder within range
        logic del_ok;         // waiter within range
        logic sweep_last;     // sweep writes its last row in this step
        logic start_end;      // all roots tried
        logic start_finished; // current root already finished
        logic cursor_end;     // successor cursor past last id
        logic cur_bit;        // edge top -> cursor present
        logic next_on_path;   // successor is on current path
        logic push_ok;        // successor not finished, path has room
        logic pop_empty;      // path holds a single node
        logic vic_match;      // path entry equals back-edge target
        logic out_busy;       // output register holds an untaken result
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/wfdd_ctrl.sv =====
// Controller state machine of the waits-for deadlock detector.
// Sequences edits, the delete sweep and the depth-first search.
// Depends on wfdd_pkg for the command and status bundles.
`default_nettype none

module wfdd_ctrl
    import wfdd_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE        = 10'b00_0000_0001,
        ST_DECODE      = 10'b00_0000_0010,
        ST_DEL_SWEEP   = 10'b00_0000_0100,
        ST_DET_START   = 10'b00_0000_1000,
        ST_DET_LOAD    = 10'b00_0001_0000,
        ST_DET_SCAN    = 10'b00_0010_0000,
        ST_DET_RESTORE = 10'b00_0100_0000,
        ST_VIC_RD      = 10'b00_1000_0000,
        ST_VIC_CMP     = 10'b01_0000_0000,
        ST_FINISH      = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (i_sts.kind_edit) begin
                    o_cmd.edit_wr = i_sts.edit_ok;
                    n_state       = ST_FINISH;
                end else if (i_sts.kind_delete) begin
                    n_state = i_sts.del_ok ? ST_DEL_SWEEP : ST_FINISH;
                end else if (i_sts.kind_clear) begin
                    o_cmd.clear_graph = 1'b1;
                    n_state           = ST_FINISH;
                end else if (i_sts.kind_detect) begin
                    o_cmd.det_init = 1'b1;
                    n_state        = ST_DET_START;
                end else begin
                    // unknown code: empty result
                    n_state = ST_FINISH;
                end
            end
            ST_DEL_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_DET_START: begin
                priority if (i_sts.start_end) begin
                    n_state = ST_FINISH;
                end else if (i_sts.start_finished) begin
                    o_cmd.start_skip = 1'b1;
                end else begin
                    o_cmd.start_push = 1'b1;
                    n_state          = ST_DET_LOAD;
                end
            end
            ST_DET_LOAD: begin
                o_cmd.load_row = 1'b1;
                n_state        = ST_DET_SCAN;
            end
            ST_DET_SCAN: begin
                priority if (i_sts.cursor_end) begin
                    o_cmd.scan_pop = 1'b1;
                    if (i_sts.pop_empty) begin
                        o_cmd.start_skip = 1'b1;
                        n_state          = ST_DET_START;
                    end else begin
                        n_state = ST_DET_RESTORE;
                    end
                end else if (!i_sts.cur_bit) begin
                    o_cmd.scan_adv = 1'b1;
                end else if (i_sts.next_on_path) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = ST_VIC_RD;
                end else if (i_sts.push_ok) begin
                    o_cmd.scan_push = 1'b1;
                    n_state         = ST_DET_LOAD;
                end else begin
                    // successor already finished
                    o_cmd.scan_adv = 1'b1;
                end
            end
            ST_DET_RESTORE: begin
                o_cmd.pop_restore = 1'b1;
                n_state           = ST_DET_LOAD;
            end
            ST_VIC_RD: begin
                o_cmd.vic_rd = 1'b1;
                n_state      = ST_VIC_CMP;
            end
            ST_VIC_CMP: begin
                o_cmd.vic_step = 1'b1;
                n_state        = i_sts.vic_match ? ST_FINISH : ST_VIC_RD;
            end
            ST_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/wfdd_datapath.sv =====
// Datapath of the waits-for deadlock detector: adjacency memory with row
// valid bits, path stack and cursor memories, search masks, output register.
// Depends on wfdd_pkg; driven by wfdd_ctrl through t_cmd / t_sts.
`default_nettype none

module wfdd_datapath
    import wfdd_pkg::*;
#(
    parameter int unsigned MAX_TXN = DEF_MAX_TXN
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire [KIND_W-1:0]       i_kind,
    input  wire [ID_FIELD_W-1:0]   i_waiter,
    input  wire [ID_FIELD_W-1:0]   i_holder,
    input  wire                    i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_cycle_found,
    output logic [ID_FIELD_W-1:0]  o_victim
);

    localparam int unsigned ID_W  = $clog2(MAX_TXN);
    localparam int unsigned CUR_W = $clog2(MAX_TXN + 1);
    localparam logic [CUR_W-1:0]   CNT_MAX = CUR_W'(MAX_TXN);
    localparam logic [CUR_W-1:0]   CNT_ONE = CUR_W'(1);
    localparam logic [CUR_W-1:0]   CNT_TWO = CUR_W'(2);
    localparam logic [MAX_TXN-1:0] BIT0    = {{(MAX_TXN-1){1'b0}}, 1'b1};

    // Latched item fields
    logic [KIND_W-1:0]     r_kind;
    logic [ID_FIELD_W-1:0] r_waiter_f;
    logic [ID_FIELD_W-1:0] r_holder_f;

    // Adjacency memory, row valid bits, registered read
    logic [MAX_TXN-1:0] mem_adj [MAX_TXN];
    logic [MAX_TXN-1:0] r_row_vld;
    logic [MAX_TXN-1:0] r_adj_rd;
    logic               r_adj_vld;

    // Path stack and successor cursor memories
    logic [ID_W-1:0]  mem_stk [MAX_TXN];
    logic [CUR_W-1:0] mem_cur [MAX_TXN];
    logic [ID_W-1:0]  r_stk_rd;
    logic [CUR_W-1:0] r_cur_rd;

    // Search state
    logic [MAX_TXN-1:0] r_on_path;
    logic [MAX_TXN-1:0] r_finished;
    logic [MAX_TXN-1:0] r_row;
    logic [CUR_W-1:0]   r_cursor;
    logic [CUR_W-1:0]   r_depth;
    logic [CUR_W-1:0]   r_start;
    logic [CUR_W-1:0]   r_sweep;
    logic [CUR_W-1:0]   r_pos;
    logic [ID_W-1:0]    r_top;
    logic [ID_W-1:0]    r_next;
    logic [ID_W-1:0]    r_best;
    logic               r_found;

    // Output register
    logic                  r_out_valid;
    logic                  r_cycle_found;
    logic [ID_FIELD_W-1:0] r_victim;

    // Derived values
    logic [ID_W-1:0]    w_waiter;
    logic [ID_W-1:0]    w_holder;
    logic [MAX_TXN-1:0] w_waiter_oh;
    logic [MAX_TXN-1:0] w_holder_oh;
    logic [MAX_TXN-1:0] w_row_eff;
    logic [CUR_W-1:0]   w_sweep_prev;
    logic [ID_W-1:0]    w_next;
    logic [CUR_W-1:0]   w_depth_m1;
    logic [CUR_W-1:0]   w_depth_m2;

    // Memory port controls
    logic               w_adj_we;
    logic [ID_W-1:0]    w_adj_wa;
    logic [MAX_TXN-1:0] w_adj_wd;
    logic               w_adj_re;
    logic [ID_W-1:0]    w_adj_ra;
    logic               w_stk_we;
    logic [ID_W-1:0]    w_stk_wa;
    logic [ID_W-1:0]    w_stk_wd;
    logic               w_stk_re;
    logic [ID_W-1:0]    w_stk_ra;

    assign w_waiter     = ID_W'(r_waiter_f);
    assign w_holder     = ID_W'(r_holder_f);
    assign w_waiter_oh  = BIT0 << w_waiter;
    assign w_holder_oh  = BIT0 << w_holder;
    assign w_row_eff    = r_adj_vld ? r_adj_rd : '0;
    assign w_sweep_prev = r_sweep - CNT_ONE;
    assign w_next       = r_cursor[ID_W-1:0];
    assign w_depth_m1   = r_depth - CNT_ONE;
    assign w_depth_m2   = r_depth - CNT_TWO;

    // Status toward the controller
    always_comb begin
        o_sts                = '0;
        o_sts.kind_edit      = (r_kind == KIND_ADD) || (r_kind == KIND_REMOVE);
        o_sts.kind_delete    = (r_kind == KIND_DELETE);
        o_sts.kind_clear     = (r_kind == KIND_CLEAR);
        o_sts.kind_detect    = (r_kind == KIND_DETECT);
        o_sts.del_ok         = int'(r_waiter_f) < MAX_TXN;
        o_sts.edit_ok        = o_sts.del_ok && (int'(r_holder_f) < MAX_TXN);
        o_sts.sweep_last     = (r_sweep == CNT_MAX);
        o_sts.start_end      = (r_start == CNT_MAX);
        o_sts.start_finished = r_finished[r_start[ID_W-1:0]];
        o_sts.cursor_end     = (r_cursor == CNT_MAX);
        o_sts.cur_bit        = r_row[w_next];
        o_sts.next_on_path   = r_on_path[w_next];
        o_sts.push_ok        = !r_finished[w_next] && (r_depth < CNT_MAX);
        o_sts.pop_empty      = (r_depth == CNT_ONE);
        o_sts.vic_match      = (r_stk_rd == r_next);
        o_sts.out_busy       = r_out_valid && !i_out_ready;
    end

    // Adjacency write port: edge edit or delete sweep
    always_comb begin
        w_adj_we = 1'b0;
        w_adj_wa = '0;
        w_adj_wd = '0;
        if (i_cmd.edit_wr) begin
            w_adj_we = 1'b1;
            w_adj_wa = w_waiter;
            w_adj_wd = (r_kind == KIND_ADD) ? (w_row_eff | w_holder_oh)
                                            : (w_row_eff & ~w_holder_oh);
        end else if (i_cmd.sweep_step && (r_sweep != '0)) begin
            w_adj_we = 1'b1;
            w_adj_wa = w_sweep_prev[ID_W-1:0];
            // deleted node loses its row and its column
            w_adj_wd = (w_sweep_prev[ID_W-1:0] == w_waiter) ? '0
                                                            : (w_row_eff & ~w_waiter_oh);
        end
    end

    // Adjacency read port address
    always_comb begin
        w_adj_re = 1'b1;
        w_adj_ra = '0;
        priority if (i_cmd.accept) begin
            w_adj_ra = ID_W'(i_waiter);
        end else if (i_cmd.sweep_step && !o_sts.sweep_last) begin
            w_adj_ra = r_sweep[ID_W-1:0];
        end else if (i_cmd.start_push) begin
            w_adj_ra = r_start[ID_W-1:0];
        end else if (i_cmd.scan_push) begin
            w_adj_ra = w_next;
        end else if (i_cmd.pop_restore) begin
            w_adj_ra = r_stk_rd;
        end else begin
            w_adj_re = 1'b0;
        end
    end

    // Path stack ports
    always_comb begin
        w_stk_we = 1'b0;
        w_stk_wa = '0;
        w_stk_wd = '0;
        if (i_cmd.start_push) begin
            w_stk_we = 1'b1;
            w_stk_wd = r_start[ID_W-1:0];
        end else if (i_cmd.scan_push) begin
            w_stk_we = 1'b1;
            w_stk_wa = r_depth[ID_W-1:0];
            w_stk_wd = w_next;
        end
    end

    always_comb begin
        w_stk_re = 1'b1;
        w_stk_ra = '0;
        priority if (i_cmd.scan_pop) begin
            w_stk_ra = w_depth_m2[ID_W-1:0];
        end else if (i_cmd.vic_rd) begin
            w_stk_ra = r_pos[ID_W-1:0];
        end else begin
            w_stk_re = 1'b0;
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (w_adj_we) begin
            mem_adj[w_adj_wa] <= w_adj_wd;
        end
        if (w_adj_re) begin
            r_adj_rd  <= mem_adj[w_adj_ra];
            r_adj_vld <= r_row_vld[w_adj_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            mem_stk[w_stk_wa] <= w_stk_wd;
        end
        if (w_stk_re) begin
            r_stk_rd <= mem_stk[w_stk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_push) begin
            mem_cur[w_depth_m1[ID_W-1:0]] <= r_cursor + CNT_ONE;
        end
        if (i_cmd.scan_pop) begin
            r_cur_rd <= mem_cur[w_depth_m2[ID_W-1:0]];
        end
    end

    // Row valid bits: reset and clear drop the whole graph at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.clear_graph) begin
            r_row_vld <= '0;
        end else if (w_adj_we) begin
            r_row_vld[w_adj_wa] <= 1'b1;
        end
    end

    // Item fields and sweep counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind     <= i_kind;
            r_waiter_f <= i_waiter;
            r_holder_f <= i_holder;
            r_sweep    <= '0;
        end else if (i_cmd.sweep_step) begin
            r_sweep <= r_sweep + CNT_ONE;
        end
    end

    // Search masks and path depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_path  <= '0;
            r_finished <= '0;
            r_depth    <= '0;
        end else if (i_cmd.det_init) begin
            r_on_path  <= '0;
            r_finished <= '0;
            r_depth    <= '0;
        end else if (i_cmd.start_push) begin
            r_on_path[r_start[ID_W-1:0]] <= 1'b1;
            r_depth                      <= CNT_ONE;
        end else if (i_cmd.scan_push) begin
            r_on_path[w_next] <= 1'b1;
            r_depth           <= r_depth + CNT_ONE;
        end else if (i_cmd.scan_pop) begin
            r_on_path[r_top]  <= 1'b0;
            r_finished[r_top] <= 1'b1;
            r_depth           <= w_depth_m1;
        end
    end

    // Root counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.det_init) begin
            r_start <= '0;
        end else if (i_cmd.start_skip) begin
            r_start <= r_start + CNT_ONE;
        end
    end

    // Top of path, its row and successor cursor
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_push) begin
            r_top    <= r_start[ID_W-1:0];
            r_cursor <= '0;
        end else if (i_cmd.scan_push) begin
            r_top    <= w_next;
            r_cursor <= '0;
        end else if (i_cmd.pop_restore) begin
            r_top    <= r_stk_rd;
            r_cursor <= r_cur_rd;
        end else if (i_cmd.scan_adv) begin
            r_cursor <= r_cursor + CNT_ONE;
        end
        if (i_cmd.load_row) begin
            r_row <= w_row_eff;
        end
    end

    // Victim walk down the path from the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_found <= 1'b0;
            r_best  <= '0;
        end else if (i_cmd.scan_hit) begin
            r_next <= w_next;
            r_best <= w_next;
            r_pos  <= w_depth_m1;
        end else if (i_cmd.vic_step) begin
            if (r_stk_rd > r_best) begin
                r_best <= r_stk_rd;
            end
            if (o_sts.vic_match) begin
                r_found <= 1'b1;
            end else begin
                r_pos <= r_pos - CNT_ONE;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_cycle_found <= r_found;
            r_victim      <= ID_FIELD_W'(r_best);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cycle_found = r_cycle_found;
    assign o_victim      = r_victim;

endmodule

`default_nettype wire

// ===== sv/waits_for_deadlock_detector_unit.sv =====
// Waits-for deadlock detector: the input channel takes one operation per
// transfer (kind, waiter, holder) and the output channel returns one result
// per operation (cycle_found, victim). For add and remove edge, clear graph
// and unknown codes the result passes the decode and finish states into the
// output register; delete node sweeps the adjacency memory one row per cycle.
// Detection scans one adjacency bit per cycle from the top's row, which is
// loaded from the adjacency memory after each push and each pop; roots are
// tried in turn, a pop restores the top id and cursor before that load, and
// reporting a cycle walks the path down from the top, comparing each entry.
// One operation is in flight at a time; input ready is high only while the
// block is idle, and a finished result sits in an output register so the
// next operation can be taken while the receiver has not yet taken it.
// If the receiver stalls with a result still held, the next result waits
// in the block until the output register frees.
// Synchronous active-low reset empties the graph (all rows marked invalid
// at once) and drops any pending result.
// Depends on wfdd_pkg, wfdd_ctrl and wfdd_datapath.
`default_nettype none

module waits_for_deadlock_detector_unit
    import wfdd_pkg::*;
#(
    parameter int unsigned MAX_TXN = DEF_MAX_TXN
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire [KIND_W-1:0]      i_kind,
    input  wire [ID_FIELD_W-1:0]  i_waiter,
    input  wire [ID_FIELD_W-1:0]  i_holder,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic                  o_cycle_found,
    output logic [ID_FIELD_W-1:0] o_victim
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    wfdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Graph storage and search datapath
    wfdd_datapath #(
        .MAX_TXN (MAX_TXN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (i_kind),
        .i_waiter      (i_waiter),
        .i_holder      (i_holder),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_cycle_found (o_cycle_found),
        .o_victim      (o_victim)
    );

endmodule

`default_nettype wire

// ===== tb/tb_waits_for_deadlock_detector_unit.sv =====
// Testbench for waits_for_deadlock_detector_unit: drives graph edits and detect
// requests, predicts each result with its own depth-first search, checks in order.
// Depends on wfdd_pkg and the waits_for_deadlock_detector_unit RTL.
module tb_waits_for_deadlock_detector_unit;
    import wfdd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TXN_COUNT = DEF_MAX_TXN;
    localparam int MAX_REPORTS = 10;

    typedef logic [ID_FIELD_W-1:0] t_txn_id;

    typedef struct {
        logic    found;
        t_txn_id victim;
    } t_verdict;

    // DUT signals
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [KIND_W-1:0]     kind = KIND_ADD;
    t_txn_id               waiter = '0;
    t_txn_id               holder = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  cycle_found;
    t_txn_id               victim;

    // Predictor state: row w, bit h set means w waits for h
    logic [TXN_COUNT-1:0]  wait_rows [TXN_COUNT];
    t_verdict              pending_verdicts [$];
    int                    mismatch_count = 0;
    bit                    no_idle = 1'b0;
    t_txn_id               id_order [TXN_COUNT];
    t_txn_id               id_window = '0;

    waits_for_deadlock_detector_unit #(
        .MAX_TXN(TXN_COUNT)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_kind(kind),
        .i_waiter(waiter),
        .i_holder(holder),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_cycle_found(cycle_found),
        .o_victim(victim)
    );

    always #5 clk = ~clk;

    // DFS from each root in ascending order; first back edge names the victim
    function automatic logic find_deadlock(output t_txn_id worst);
        logic [TXN_COUNT-1:0] done_set;
        logic [TXN_COUNT-1:0] path_set;
        t_txn_id              stack_ids [TXN_COUNT];
        int                   cursor [TXN_COUNT];
        int                   depth;
        int                   top_pos;
        int                   next;
        int                   pos;
        t_txn_id              top_id;
        t_txn_id              best;
        done_set = '0;
        path_set = '0;
        worst = '0;
        for (int root = 0; root < TXN_COUNT; root++) begin
            if (done_set[root])
                continue;
            stack_ids[0] = t_txn_id'(root);
            cursor[0] = 0;
            path_set[root] = 1'b1;
            depth = 1;
            while (depth > 0) begin
                top_pos = depth - 1;
                top_id = stack_ids[top_pos];
                next = cursor[top_pos];
                while (next < TXN_COUNT && !wait_rows[top_id][next])
                    next++;
                if (next >= TXN_COUNT) begin
                    path_set[top_id] = 1'b0;
                    done_set[top_id] = 1'b1;
                    depth--;
                    continue;
                end
                cursor[top_pos] = next + 1;
                if (path_set[next]) begin
                    // walk down the path to the back-edge target
                    best = t_txn_id'(next);
                    pos = top_pos + 1;
                    while (pos > 0) begin
                        pos--;
                        if (stack_ids[pos] > best)
                            best = stack_ids[pos];
                        if (stack_ids[pos] == t_txn_id'(next))
                            break;
                    end
                    worst = best;
                    return 1'b1;
                end
                if (!done_set[next] && depth < TXN_COUNT) begin
                    stack_ids[depth] = t_txn_id'(next);
                    cursor[depth] = 0;
                    path_set[next] = 1'b1;
                    depth++;
                end
            end
        end
        return 1'b0;
    endfunction

    // Apply one operation to the graph copy and return its expected result
    function automatic t_verdict apply_wait_op(input logic [KIND_W-1:0] op,
                                               input t_txn_id w, input t_txn_id h);
        t_verdict res;
        res.found = 1'b0;
        res.victim = '0;
        case (op)
            KIND_ADD: wait_rows[w][h] = 1'b1;
            KIND_REMOVE: wait_rows[w][h] = 1'b0;
            KIND_DELETE: begin
                wait_rows[w] = '0;
                for (int i = 0; i < TXN_COUNT; i++)
                    wait_rows[i][w] = 1'b0;
            end
            KIND_CLEAR: begin
                for (int i = 0; i < TXN_COUNT; i++)
                    wait_rows[i] = '0;
            end
            KIND_DETECT: res.found = find_deadlock(res.victim);
            default: ;
        endcase
        return res;
    endfunction

    // One input transfer; valid stays up after acceptance until the next call
    task automatic issue_op(input logic [KIND_W-1:0] op, input t_txn_id w, input t_txn_id h);
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        waiter <= w;
        holder <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_verdicts.push_back(apply_wait_op(op, w, h));
    endtask

    function automatic t_txn_id any_id();
        return t_txn_id'($urandom_range(TXN_COUNT - 1));
    endfunction

    // Half the ids land in a small moving window so edges pile up there
    function automatic t_txn_id graph_id();
        if ($urandom_range(1) == 0)
            return any_id();
        return t_txn_id'(id_window + $urandom_range(5));
    endfunction

    function automatic logic [KIND_W-1:0] bad_kind();
        return KIND_DETECT + KIND_W'($urandom_range(1, 3));
    endfunction

    task automatic shuffle_ids();
        int j;
        t_txn_id t;
        for (int i = 0; i < TXN_COUNT; i++)
            id_order[i] = t_txn_id'(i);
        for (int i = TXN_COUNT - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = id_order[i];
            id_order[i] = id_order[j];
            id_order[j] = t;
        end
    endtask

    // Extreme ids, every kind, self edge, duplicate add, absent remove
    task automatic test_basic_ops();
        issue_op(KIND_DETECT, 5'd0, 5'd0);
        issue_op(KIND_ADD, 5'd0, 5'd31);
        issue_op(KIND_ADD, 5'd0, 5'd31);
        issue_op(KIND_REMOVE, 5'd12, 5'd7);
        issue_op(KIND_DETECT, 5'd31, 5'd31);
        issue_op(KIND_ADD, 5'd31, 5'd0);
        issue_op(KIND_DETECT, 5'd31, 5'd0);
        issue_op(KIND_REMOVE, 5'd31, 5'd0);
        issue_op(KIND_DETECT, 5'd0, 5'd31);
        issue_op(KIND_DETECT + 3'd1, 5'd31, 5'd31);
        issue_op(KIND_DETECT + 3'd2, 5'd21, 5'd10);
        issue_op(KIND_DETECT + 3'd3, 5'd10, 5'd21);
        issue_op(KIND_ADD, 5'd17, 5'd17);
        issue_op(KIND_DETECT, 5'd17, 5'd17);
        issue_op(KIND_DELETE, 5'd17, 5'd3);
        issue_op(KIND_ADD, 5'd3, 5'd9);
        issue_op(KIND_ADD, 5'd9, 5'd5);
        issue_op(KIND_ADD, 5'd5, 5'd3);
        issue_op(KIND_DETECT, 5'd0, 5'd0);
        issue_op(KIND_DELETE, 5'd9, 5'd31);
        issue_op(KIND_DETECT, 5'd0, 5'd0);
        issue_op(KIND_CLEAR, 5'd31, 5'd31);
        issue_op(KIND_DETECT, 5'd0, 5'd0);
    endtask

    // Longest path through all ids, then close it for a full-length victim walk
    task automatic test_long_path();
        no_idle = 1'b1;
        issue_op(KIND_CLEAR, 5'd0, 5'd0);
        for (int i = 0; i + 1 < TXN_COUNT; i++)
            issue_op(KIND_ADD, t_txn_id'(i), t_txn_id'(i + 1));
        issue_op(KIND_DETECT, 5'd0, 5'd0);
        issue_op(KIND_ADD, 5'd31, 5'd0);
        issue_op(KIND_DETECT, 5'd0, 5'd0);
        issue_op(KIND_CLEAR, 5'd0, 5'd0);
        no_idle = 1'b0;
    endtask

    // Well-formed wait chains, mostly closed into rings, then broken again
    task automatic test_wait_rings(input int rounds);
        int len;
        int cut;
        for (int r = 0; r < rounds; r++) begin
            shuffle_ids();
            len = $urandom_range(1, 8);
            if ($urandom_range(9) == 0)
                len = $urandom_range(9, TXN_COUNT);
            issue_op(KIND_CLEAR, any_id(), any_id());
            for (int i = 0; i + 1 < len; i++)
                issue_op(KIND_ADD, id_order[i], id_order[i + 1]);
            if ($urandom_range(3) != 0)
                issue_op(KIND_ADD, id_order[len - 1], id_order[0]);
            repeat ($urandom_range(2))
                issue_op(KIND_ADD, any_id(), any_id());
            issue_op(KIND_DETECT, any_id(), any_id());
            cut = $urandom_range(len - 1);
            if ($urandom_range(1) == 0)
                issue_op(KIND_DELETE, id_order[cut], any_id());
            else
                issue_op(KIND_REMOVE, id_order[cut], id_order[(cut + 1) % len]);
            issue_op(KIND_DETECT, any_id(), any_id());
        end
    endtask

    // Random mix of all kinds over random graphs
    task automatic test_random_mix(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0)
                id_window = any_id();
            pick = $urandom_range(99);
            if (pick < 42)
                issue_op(KIND_ADD, graph_id(), graph_id());
            else if (pick < 56)
                issue_op(KIND_REMOVE, graph_id(), graph_id());
            else if (pick < 63)
                issue_op(KIND_DELETE, graph_id(), any_id());
            else if (pick < 66)
                issue_op(KIND_CLEAR, any_id(), any_id());
            else if (pick < 96)
                issue_op(KIND_DETECT, any_id(), any_id());
            else
                issue_op(bad_kind(), any_id(), any_id());
        end
    endtask

    // Receiver side: stalls about 9 percent of the time
    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= 9);

    // Compare each result transfer with the oldest expectation
    always @(posedge clk) begin
        t_verdict exp_v;
        if (rst_n && out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: found=%0b victim=%0d", cycle_found, victim);
            end else begin
                exp_v = pending_verdicts.pop_front();
                if (cycle_found !== exp_v.found || victim !== exp_v.victim) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result mismatch: expected found=%0b victim=%0d, got found=%0b victim=%0d",
                                 exp_v.found, exp_v.victim, cycle_found, victim);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < TXN_COUNT; i++)
            wait_rows[i] = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_basic_ops();
        test_long_path();
        test_wait_rings(70);
        test_random_mix(330);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Timeout well above the slowest legal run
    initial begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

endmodule
